// File: hw/rtl/i64alu_pkg.sv
// ----------------------------------------------------------------------------
// i64alu_pkg
// Opcodes and the stage-to-stage control word of the integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package i64alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_IDIV = 5'd3,
        OP_MOD  = 5'd4,
        OP_NEG  = 5'd5,
        OP_AND  = 5'd6,
        OP_OR   = 5'd7,
        OP_XOR  = 5'd8,
        OP_NOT  = 5'd9,
        OP_SHL  = 5'd10,
        OP_SHR  = 5'd11,
        OP_ASHR = 5'd12,
        OP_EQ   = 5'd13,
        OP_LT   = 5'd14,
        OP_LE   = 5'd15,
        OP_ULT  = 5'd16
    } op_t;

    // Division bookkeeping carried alongside the divider pipeline.
    typedef struct packed {
        logic is_div;
        logic is_mod;
        logic zero;
        logic neg_one;
        logic na;
        logic nb;
    } div_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/int64_alu_floor_division.sv
// ----------------------------------------------------------------------------
// int64_alu_floor_division
// Pipelined 64-bit integer ALU with floored division and modulo.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata = cmd[4:0], lhs, rhs (zero padded to 136 bits)
// m_axis   out  tdata = value, truth, div_zero (zero padded to 72 bits)
//
// The pipeline depth is set by the divider, which retires four quotient
// bits per stage. One transfer is accepted per cycle while the output
// is not stalled. The whole pipe advances only when the output register
// is empty or being drained, so a stall holds every stage. Reset clears
// the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module int64_alu_floor_division
    import i64alu_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,   // cmd[4:0], lhs[68:5], rhs[132:69]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [71:0]  m_axis_tdata    // value[63:0], truth[64], div_zero[65]
);

    localparam int W     = DATA_WIDTH;
    localparam int STEPS = 4;
    localparam int NST   = (W + STEPS - 1) / STEPS;
    localparam int LAT   = NST + 2;            // stages after input register

    logic en;
    logic [LAT:0] v_reg;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-1:0], s_axis_tvalid};
    end

    // Stage 0: operands cut to W bits.
    logic [4:0]   cmd_in;
    logic [W-1:0] a_in, b_in;
    assign cmd_in = s_axis_tdata[4:0];
    assign a_in   = s_axis_tdata[5 +: W];
    assign b_in   = s_axis_tdata[69 +: W];

    logic [4:0]   cmd_reg;
    logic [W-1:0] a_reg, b_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg <= cmd_in;
            a_reg   <= a_in;
            b_reg   <= b_in;
        end
    end

    // Stage 1: everything but division and multiply; prepare divider magnitudes.
    function automatic logic [W-1:0] shift_f(logic [W-1:0] x, logic left,
                                             logic [W-1:0] mag, logic arith);
        logic sat;
        sat = mag >= W'(W);
        if (sat)
            return (!left && arith && x[W-1]) ? '1 : '0;
        if (left)
            return x << mag;
        if (arith)
            return $signed(x) >>> mag;
        return x >> mag;
    endfunction

    logic [W-1:0] fast_val, ma, mb;
    logic         fast_truth;
    logic [W-1:0] neg_b;
    logic         sgn_lt;
    div_ctl_t     dctl;

    always_comb
    begin
        neg_b      = -b_reg;
        sgn_lt     = $signed(a_reg) < $signed(b_reg);
        fast_val   = '0;
        fast_truth = 1'b0;
        case (cmd_reg)
            OP_ADD:  fast_val = a_reg + b_reg;
            OP_SUB:  fast_val = a_reg - b_reg;
            OP_MUL:  fast_val = '0;   // product joins one stage later
            OP_NEG:  fast_val = -a_reg;
            OP_AND:  fast_val = a_reg & b_reg;
            OP_OR:   fast_val = a_reg | b_reg;
            OP_XOR:  fast_val = a_reg ^ b_reg;
            OP_NOT:  fast_val = ~a_reg;
            OP_SHL:  fast_val = b_reg[W-1] ? shift_f(a_reg, 1'b0, neg_b, 1'b0)
                                           : shift_f(a_reg, 1'b1, b_reg, 1'b0);
            OP_SHR, OP_ASHR:
                fast_val = (b_reg != '0 && !b_reg[W-1])
                    ? shift_f(a_reg, 1'b0, b_reg, cmd_reg == OP_ASHR)
                    : shift_f(a_reg, 1'b1, neg_b, cmd_reg == OP_ASHR);
            OP_EQ:   fast_truth = a_reg == b_reg;
            OP_LT:   fast_truth = sgn_lt;
            OP_LE:   fast_truth = sgn_lt || (a_reg == b_reg);
            OP_ULT:  fast_truth = a_reg < b_reg;
            default: ;
        endcase
        dctl.is_div  = cmd_reg == OP_IDIV;
        dctl.is_mod  = cmd_reg == OP_MOD;
        dctl.zero    = b_reg == '0;
        dctl.neg_one = b_reg == '1;
        dctl.na      = a_reg[W-1];
        dctl.nb      = b_reg[W-1];
        ma = a_reg[W-1] ? -a_reg : a_reg;
        mb = b_reg[W-1] ? neg_b : b_reg;
    end

    // Multiply: half-width partial products here, summed in the next stage.
    // Only the low W bits are kept, so the high-by-high product is dropped.
    localparam int HL = (W + 1) / 2;
    localparam int HH = W - HL;
    localparam int PW = 2 * HL;

    logic [PW-1:0] mul_ll, mul_ll_reg;
    logic [HH-1:0] mul_x, mul_x_reg;
    logic          mul_sel_reg;
    logic [W-1:0]  mul_val;

    assign mul_ll = PW'(a_reg[HL-1:0]) * PW'(b_reg[HL-1:0]);
    assign mul_x  = HH'(a_reg[HL-1:0] * b_reg[W-1:HL])
                  + HH'(a_reg[W-1:HL] * b_reg[HL-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_ll_reg  <= mul_ll;
            mul_x_reg   <= mul_x;
            mul_sel_reg <= cmd_reg == OP_MUL;
        end
    end

    assign mul_val = W'(mul_ll_reg + PW'({mul_x_reg, {HL{1'b0}}}));

    // Side pipe that travels with the divider.
    logic [W-1:0] fv_reg [NST+1];
    logic         ft_reg [NST+1];
    div_ctl_t     dc_reg [NST+1];
    logic [W-1:0] an_reg [NST+1];
    logic [W-1:0] bs_reg [NST+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fv_reg[0] <= fast_val;
            ft_reg[0] <= fast_truth;
            dc_reg[0] <= dctl;
            an_reg[0] <= -a_reg;
            bs_reg[0] <= b_reg;
            fv_reg[1] <= mul_sel_reg ? mul_val : fv_reg[0];
            for (int i = 2; i <= NST; i++)
                fv_reg[i] <= fv_reg[i-1];
            for (int i = 1; i <= NST; i++)
            begin
                ft_reg[i] <= ft_reg[i-1];
                dc_reg[i] <= dc_reg[i-1];
                an_reg[i] <= an_reg[i-1];
                bs_reg[i] <= bs_reg[i-1];
            end
        end
    end

    logic [W-1:0] ma_reg, mb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg <= ma;
            mb_reg <= mb;
        end
    end

    logic [W-1:0] quo, rem;
    i64alu_div #(.W(W), .STEPS(STEPS)) u_div (
        .clk (clk),
        .en  (en),
        .num (ma_reg),
        .den (mb_reg),
        .quo (quo),
        .rem (rem)
    );

    // Final stage: floored fixup and result select.
    // The divider's last stage lines up with side index NST.
    div_ctl_t     dc;
    logic [W-1:0] res_val, q_s, r_s;
    logic         diff;
    always_comb
    begin
        dc      = dc_reg[NST];
        diff    = dc.na != dc.nb;
        q_s     = diff ? -quo : quo;
        if (diff && rem != '0)
            q_s = q_s - 1'b1;
        r_s     = dc.na ? -rem : rem;
        if (diff && rem != '0)
            r_s = r_s + bs_reg[NST];
        res_val = fv_reg[NST];
        if (dc.is_div || dc.is_mod)
        begin
            if (dc.zero)
                res_val = '0;
            else if (dc.neg_one)
                res_val = dc.is_div ? an_reg[NST] : '0;
            else
                res_val = dc.is_div ? q_s : r_s;
        end
    end

    logic [W-1:0] val_reg;
    logic         tr_reg, dz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= res_val;
            tr_reg  <= ft_reg[NST];
            dz_reg  <= (dc.is_div || dc.is_mod) && dc.zero;
        end
    end

    assign m_axis_tdata = {6'd0, dz_reg, tr_reg, {(64-W){val_reg[W-1]}}, val_reg};

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_dz_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[65] && m_axis_tdata[64]))
        else $error("div_zero with truth");
    a_dz_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[63:0] == '0)
        else $error("div_zero with nonzero value");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stall with empty output");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/i64alu_div.sv
// ----------------------------------------------------------------------------
// i64alu_div
// Pipelined unsigned restoring divider, STEPS quotient bits per stage.
// Each stage registers the partial remainder, shifted dividend, quotient and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module i64alu_div
    import i64alu_pkg::*;
#(
    parameter int W     = 64,
    parameter int STEPS = 4
)
(
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic      [W-1:0] quo,
    output logic      [W-1:0] rem
);

    localparam int NST = (W + STEPS - 1) / STEPS;

    logic [W-1:0] r_reg [NST+1];
    logic [W-1:0] n_reg [NST+1];
    logic [W-1:0] q_reg [NST+1];
    logic [W-1:0] d_reg [NST+1];

    always_comb
    begin
        r_reg[0] = '0;
        n_reg[0] = num;
        q_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        logic [W-1:0] r_next, n_next, q_next;
        always_comb
        begin
            logic [W:0] t;
            t      = '0;
            r_next = r_reg[s];
            n_next = n_reg[s];
            q_next = q_reg[s];
            for (int k = 0; k < STEPS; k++)
            begin
                if (s * STEPS + k < W)
                begin
                    t = {r_next, n_next[W-1]};
                    n_next = {n_next[W-2:0], 1'b0};
                    if (t >= {1'b0, d_reg[s]})
                    begin
                        t = t - {1'b0, d_reg[s]};
                        q_next = {q_next[W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next = {q_next[W-2:0], 1'b0};
                    end
                    r_next = t[W-1:0];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1] <= r_next;
                n_reg[s+1] <= n_next;
                q_reg[s+1] <= q_next;
                d_reg[s+1] <= d_reg[s];
            end
        end
    end

    assign quo = q_reg[NST];
    assign rem = r_reg[NST];

endmodule

`default_nettype wire

// File: sim/alu_checker.sv
// ----------------------------------------------------------------------------
// alu_checker
// Watches both stream channels of the integer ALU, computes the expected
// result of every accepted operation and compares it with the output order.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_checker
    import i64alu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [71:0]  m_axis_tdata,
    output int                errors,
    output int                pending,
    output int                results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        div_zero;
        logic        truth;
        logic [63:0] value;
    } alu_result_t;

    alu_result_t expected_q[$];

    // Shift x by an exact magnitude; saturate at 64 and beyond.
    function automatic logic [63:0] shift_by(logic [63:0] x, bit left,
                                             logic [63:0] mag, bit arith);
        logic fill;
        fill = arith && x[63];
        if (mag >= 64)
            return (!left && fill) ? '1 : '0;
        if (left)
            return x << mag[5:0];
        if (fill)
            return ~((~x) >> mag[5:0]);
        return x >> mag[5:0];
    endfunction

    function automatic alu_result_t compute_result(logic [4:0] cmd,
                                                   logic [63:0] a, logic [63:0] b);
        alu_result_t r;
        logic [63:0] ma, mb, q, rem, t;
        bit na, nb;
        r = '0;
        na = a[63];
        nb = b[63];
        case (cmd)
            OP_ADD:  r.value = a + b;
            OP_SUB:  r.value = a - b;
            OP_MUL:  r.value = a * b;
            OP_IDIV, OP_MOD:
            begin
                if (b == 0)
                    r.div_zero = 1'b1;
                else if (b == '1)
                    r.value = (cmd == OP_IDIV) ? 64'(0 - a) : 64'd0;
                else
                begin
                    ma = na ? 64'(0 - a) : a;
                    mb = nb ? 64'(0 - b) : b;
                    q = ma / mb;
                    rem = ma % mb;
                    if (cmd == OP_IDIV)
                    begin
                        t = (na != nb) ? 64'(0 - q) : q;
                        if (na != nb && rem != 0)
                            t = t - 1;
                    end
                    else
                    begin
                        t = na ? 64'(0 - rem) : rem;
                        if (rem != 0 && na != nb)
                            t = t + b;
                    end
                    r.value = t;
                end
            end
            OP_NEG:  r.value = 0 - a;
            OP_AND:  r.value = a & b;
            OP_OR:   r.value = a | b;
            OP_XOR:  r.value = a ^ b;
            OP_NOT:  r.value = ~a;
            OP_SHL:
                r.value = nb ? shift_by(a, 0, 64'(0 - b), 0) : shift_by(a, 1, b, 0);
            OP_SHR, OP_ASHR:
                if (b != 0 && !nb)
                    r.value = shift_by(a, 0, b, cmd == OP_ASHR);
                else
                    r.value = shift_by(a, 1, 64'(0 - b), cmd == OP_ASHR);
            OP_EQ:   r.truth = (a == b);
            OP_LT:   r.truth = $signed(a) < $signed(b);
            OP_LE:   r.truth = $signed(a) <= $signed(b);
            OP_ULT:  r.truth = a < b;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want, got;
        if (!rst_n)
        begin
            errors <= 0;
            results_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(compute_result(s_axis_tdata[4:0],
                    s_axis_tdata[68:5], s_axis_tdata[132:69]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[65:0];
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: %h", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[71:66] !== 6'd0)
                    begin
                        if (errors < 10)
                            $display("mismatch: value exp %h got %h, truth exp %b got %b, div_zero exp %b got %b",
                                     want.value, got.value, want.truth, got.truth,
                                     want.div_zero, got.div_zero);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the integer ALU with random
// gaps and output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import i64alu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 1100;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 40;
    localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    int           errors, pending, results_seen;
    int           cycles = 0;
    int           sent = 0;
    bit           stall_hold = 1'b0;

    always #6 clk = ~clk;

    int64_alu_floor_division DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    alu_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // Output side: a random stall (possibly none) before each result, none while stall_hold is set.
    initial
    begin
        int wait_n;
        forever
        begin
            wait_n = stall_hold ? 0 : $urandom_range(0, 3);
            if (wait_n != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_S;
            1: return MAX_S;
            2: return '1;
            3: return 64'(signed'($urandom_range(0, 40)) - 20);
            4: return 64'($urandom_range(0, 70));
            5: return 0 - 64'($urandom_range(0, 70));
            6: return 64'($urandom());
            default: return rand64();
        endcase
    endfunction

    task automatic send_op(logic [4:0] cmd, logic [63:0] lhs, logic [63:0] rhs);
        int gap;
        gap = stall_hold ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rhs, lhs, cmd};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic idle_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [4:0] cmd;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: each operation, floor division signs, divide
        // by zero and by minus one, saturating and negative shifts, a bad opcode.
        for (int op = 0; op <= OP_ULT; op++)
            send_op(5'(op), MAX_S, 64'd3);
        send_op(OP_IDIV, 64'd7, 64'hffff_ffff_ffff_fffe);
        send_op(OP_MOD,  64'd7, 64'hffff_ffff_ffff_fffe);
        send_op(OP_IDIV, 0 - 64'd7, 64'd2);
        send_op(OP_MOD,  0 - 64'd7, 64'd2);
        send_op(OP_IDIV, MIN_S, '1);
        send_op(OP_MOD,  MIN_S, '1);
        send_op(OP_IDIV, 64'd5, 64'd0);
        send_op(OP_SHL,  64'd1, MIN_S);
        send_op(OP_ASHR, MIN_S, 64'd64);
        send_op(OP_ASHR, MIN_S, 0 - 64'd4);
        send_op(OP_SHR,  MIN_S, 64'd63);
        send_op(5'd31,   MAX_S, MIN_S);

        // Let the pipe empty completely once before the random part.
        idle_until_drained();

        stall_hold = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200) stall_hold = 1'b0;
            cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
            send_op(cmd, pick_operand(), pick_operand());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operations over all opcodes, %0d results checked",
                 sent, results_seen);
        if (errors == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
